[sv/ows_pkg.sv]
// Shared types and constants of the 1-Wire ROM search engine
package ows_pkg;

	localparam int RomBits      = 64;
	localparam int RomIdxBits   = $clog2(RomBits);
	localparam int PosBits      = 7;
	localparam int FamDiscBits  = 4;
	localparam int OutDepth     = 4;
	localparam int OutPtrBits   = $clog2(OutDepth);
	localparam int OutCntBits   = OutPtrBits + 1;

	localparam logic [PosBits-1:0] PosFirst  = PosBits'(1);
	localparam logic [PosBits-1:0] PosLast   = PosBits'(RomBits);
	localparam logic [PosBits-1:0] PosFamEnd = PosBits'(9);
	localparam logic [PosBits-1:0] PosNone   = '0;

	localparam logic [7:0] ResetSearchCmd = 8'hF0;

	localparam logic [2:0] CMD_NEXT     = 3'd0;
	localparam logic [2:0] CMD_FIRST    = 3'd1;
	localparam logic [2:0] CMD_VERIFY   = 3'd2;
	localparam logic [2:0] CMD_TARGET   = 3'd3;
	localparam logic [2:0] CMD_FAM_SKIP = 3'd4;
	localparam logic [2:0] CMD_PRESENCE = 3'd5;
	localparam logic [2:0] CMD_BIT_PAIR = 3'd6;

	localparam logic [1:0] ACT_BUS_RESET = 2'd0;
	localparam logic [1:0] ACT_WR_BYTE   = 2'd1;
	localparam logic [1:0] ACT_WR_DIR    = 2'd2;
	localparam logic [1:0] ACT_FINISH    = 2'd3;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_PRESENCE = 2'd1;
	localparam logic [1:0] PH_SEARCH   = 2'd2;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] fam_byte;
		logic       no_presence;
		logic       id_bit;
		logic       cmp_bit;
	} ows_in_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         out_byte;
		logic               direction;
		logic               found;
		logic [RomBits-1:0] rom_code;
		logic               last_device;
		logic               last;
	} ows_out_t;

	typedef struct packed {
		logic [1:0] count;
		ows_out_t   res0;
		ows_out_t   res1;
	} ows_step_t;

endpackage

[sv/ows_core.sv]
// Search state registers and per-item decision logic
module ows_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ows_pkg::ows_in_t  item,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	output ows_pkg::ows_step_t step
);
	import ows_pkg::*;

	logic [7:0]             search_cmd_q;
	logic [RomBits-1:0]     rom_q, saved_rom_q, n_rom;
	logic [PosBits-1:0]     ld_q, saved_ld_q, n_ld;
	logic [FamDiscBits-1:0] lfd_q, saved_lfd_q, n_lfd;
	logic                   ldf_q, saved_ldf_q, n_ldf;
	logic [PosBits-1:0]     bp_q, n_bp, lzp_q, n_lzp;
	logic [1:0]             phase_q, n_phase;
	logic                   verify_q, n_verify;
	logic [RomBits-1:0]     n_saved_rom;
	logic [PosBits-1:0]     n_saved_ld;
	logic [FamDiscBits-1:0] n_saved_lfd;
	logic                   n_saved_ldf;
	ows_step_t              res;

	always_comb begin
		logic                      concl;
		logic                      ok;
		logic                      fnd;
		logic                      second;
		logic                      dir;
		logic [PosBits-1:0]        pos;
		logic [RomIdxBits-1:0]     idx;
		ows_out_t                  fin;

		n_rom       = rom_q;
		n_ld        = ld_q;
		n_lfd       = lfd_q;
		n_ldf       = ldf_q;
		n_bp        = bp_q;
		n_lzp       = lzp_q;
		n_phase     = phase_q;
		n_verify    = verify_q;
		n_saved_rom = saved_rom_q;
		n_saved_ld  = saved_ld_q;
		n_saved_lfd = saved_lfd_q;
		n_saved_ldf = saved_ldf_q;
		res         = '0;
		concl       = 1'b0;
		ok          = 1'b0;
		fnd         = 1'b0;
		second      = 1'b0;
		dir         = 1'b0;
		pos         = PosFirst;
		idx         = '0;
		fin         = '0;

		// NEXT, FIRST, VERIFY, TARGET and FAM_SKIP abandon any running search first
		if (item.cmd <= CMD_FAM_SKIP) begin
			if (verify_q) begin
				n_rom = saved_rom_q;
				n_ld  = saved_ld_q;
				n_lfd = saved_lfd_q;
				n_ldf = saved_ldf_q;
			end
			n_verify = 1'b0;
			n_phase  = PH_IDLE;
		end

		unique case (item.cmd)
			CMD_NEXT: begin
				if (n_ldf) begin
					concl = 1'b1;
				end else begin
					n_phase          = PH_PRESENCE;
					res.count        = 2'd1;
					res.res0.action  = ACT_BUS_RESET;
					res.res0.last    = 1'b1;
				end
			end
			CMD_FIRST: begin
				n_ld            = PosNone;
				n_lfd           = '0;
				n_ldf           = 1'b0;
				n_phase         = PH_PRESENCE;
				res.count       = 2'd1;
				res.res0.action = ACT_BUS_RESET;
				res.res0.last   = 1'b1;
			end
			CMD_VERIFY: begin
				n_saved_rom     = n_rom;
				n_saved_ld      = n_ld;
				n_saved_lfd     = n_lfd;
				n_saved_ldf     = n_ldf;
				n_ld            = PosLast;
				n_ldf           = 1'b0;
				n_verify        = 1'b1;
				n_phase         = PH_PRESENCE;
				res.count       = 2'd1;
				res.res0.action = ACT_BUS_RESET;
				res.res0.last   = 1'b1;
			end
			CMD_TARGET: begin
				n_rom = RomBits'(item.fam_byte);
				n_ld  = PosLast;
				n_lfd = '0;
				n_ldf = 1'b0;
			end
			CMD_FAM_SKIP: begin
				n_ld  = PosBits'(n_lfd);
				n_lfd = '0;
				if (n_ld == PosNone)
					n_ldf = 1'b1;
			end
			CMD_PRESENCE: begin
				if (phase_q == PH_PRESENCE) begin
					if (item.no_presence) begin
						concl = 1'b1;
					end else begin
						n_phase           = PH_SEARCH;
						n_bp              = PosFirst;
						n_lzp             = PosNone;
						res.count         = 2'd1;
						res.res0.action   = ACT_WR_BYTE;
						res.res0.out_byte = search_cmd_q;
						res.res0.last     = 1'b1;
					end
				end
			end
			CMD_BIT_PAIR: begin
				if (phase_q == PH_SEARCH) begin
					if (item.id_bit && item.cmp_bit) begin
						concl = 1'b1;
					end else begin
						pos = (bp_q == PosNone || bp_q > PosLast) ? PosFirst : bp_q;
						idx = RomIdxBits'(pos - PosFirst);
						if (item.id_bit != item.cmp_bit) begin
							dir = item.id_bit;
						end else begin
							if (pos < ld_q)
								dir = rom_q[idx];
							else
								dir = (pos == ld_q);
							if (!dir) begin
								n_lzp = pos;
								if (pos < PosFamEnd)
									n_lfd = pos[FamDiscBits-1:0];
							end
						end
						n_rom[idx]         = dir;
						n_bp               = pos + PosFirst;
						res.count          = 2'd1;
						res.res0.action    = ACT_WR_DIR;
						res.res0.direction = dir;
						res.res0.last      = 1'b1;
						if (pos == PosLast) begin
							res.res0.last = 1'b0;
							n_ld          = n_lzp;
							if (n_lzp == PosNone)
								n_ldf = 1'b1;
							ok     = (n_rom[7:0] != 8'd0);
							concl  = 1'b1;
							second = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		if (concl) begin
			fnd = ok;
			if (!ok) begin
				n_ld  = PosNone;
				n_lfd = '0;
				n_ldf = 1'b0;
			end
			if (n_verify) begin
				fnd   = ok && (n_rom == saved_rom_q);
				n_rom = saved_rom_q;
				n_ld  = saved_ld_q;
				n_lfd = saved_lfd_q;
				n_ldf = saved_ldf_q;
			end
			n_verify        = 1'b0;
			n_phase         = PH_IDLE;
			fin.action      = ACT_FINISH;
			fin.found       = fnd;
			fin.rom_code    = n_rom;
			fin.last_device = n_ldf;
			fin.last        = 1'b1;
			if (second) begin
				res.count = 2'd2;
				res.res1  = fin;
			end else begin
				res.count = 2'd1;
				res.res0  = fin;
			end
		end
	end

	assign step = fire ? res : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_cmd_q <= ResetSearchCmd;
			rom_q        <= '0;
			ld_q         <= PosNone;
			lfd_q        <= '0;
			ldf_q        <= 1'b0;
			bp_q         <= PosFirst;
			lzp_q        <= PosNone;
			phase_q      <= PH_IDLE;
			verify_q     <= 1'b0;
			saved_rom_q  <= '0;
			saved_ld_q   <= PosNone;
			saved_lfd_q  <= '0;
			saved_ldf_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				search_cmd_q <= cfg_wr_data;
			if (fire) begin
				rom_q       <= n_rom;
				ld_q        <= n_ld;
				lfd_q       <= n_lfd;
				ldf_q       <= n_ldf;
				bp_q        <= n_bp;
				lzp_q       <= n_lzp;
				phase_q     <= n_phase;
				verify_q    <= n_verify;
				saved_rom_q <= n_saved_rom;
				saved_ld_q  <= n_saved_ld;
				saved_lfd_q <= n_saved_lfd;
				saved_ldf_q <= n_saved_ldf;
			end
		end
	end

`ifndef ASSERT_OFF
	a_verify_active: assert property (@(posedge clk) disable iff (!arst_n)
		verify_q |-> phase_q != PH_IDLE)
		else $error("verify backup held outside a search");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bp_q >= PosFirst && bp_q <= PosLast + PosFirst)
		else $error("bit position out of range");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		step.count == 2'd2 |-> !step.res0.last && step.res1.action == ACT_FINISH
			&& phase_q == PH_SEARCH)
		else $error("second result not a search finish");
`endif

endmodule

[sv/ows_out_fifo.sv]
// Result queue taking up to two items per cycle and giving one per cycle unless stalled
module ows_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  ows_pkg::ows_step_t step,
	output logic              space_ok,
	output logic              valid,
	input  logic              stall,
	output ows_pkg::ows_out_t item
);
	import ows_pkg::*;

	ows_out_t               mem [OutDepth];
	logic [OutPtrBits-1:0]  wr_q, rd_q;
	logic [OutCntBits-1:0]  cnt_q;
	logic                   pop;
	logic [OutPtrBits-1:0]  wr_next;

	assign valid    = (cnt_q != '0);
	assign item     = mem[rd_q];
	assign pop      = valid && !stall;
	assign space_ok = (cnt_q <= OutCntBits'(OutDepth - 2));
	assign wr_next  = wr_q + OutPtrBits'(1);

	always_ff @(posedge clk) begin
		if (step.count != 2'd0)
			mem[wr_q] <= step.res0;
		if (step.count == 2'd2)
			mem[wr_next] <= step.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + OutPtrBits'(step.count);
			if (pop)
				rd_q <= rd_q + OutPtrBits'(1);
			cnt_q <= cnt_q + OutCntBits'(step.count) - OutCntBits'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OutCntBits'(OutDepth))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		step.count != 2'd0 |-> space_ok)
		else $error("push without room");

	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		OutPtrBits'(wr_q - rd_q) == cnt_q[OutPtrBits-1:0])
		else $error("queue count out of step with pointers");
`endif

endmodule

[sv/one_wire_rom_search.sv]
// Top level of the 1-Wire ROM search decision engine
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | in_item  (ows_in_t)
//  out     | from block| out_valid/out_stall| out_item (ows_out_t)
//  cfg     | to block  | cfg_wr_en          | cfg_wr_data (search command byte)
//
// One item per cycle while in_stall is low: input register, combinational decision logic, a four-deep result queue.
// A result passes through the input register and the result queue before it is offered; a final bit pair gives two.
// arst_n clears all search state; the search command byte returns to 0xF0.
// in_stall: an item waits in the input register and the queue has under two free places.
module one_wire_rom_search (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ows_pkg::ows_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output ows_pkg::ows_out_t out_item,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data
);
	import ows_pkg::*;

	ows_in_t   item_s1;
	logic      valid_s1;
	logic      fire;
	logic      accept;
	logic      space_ok;
	ows_step_t step;

	assign fire     = valid_s1 && space_ok;
	assign in_stall = valid_s1 && !space_ok;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_item;
	end

	ows_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (step)
	);

	ows_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.space_ok (space_ok),
		.valid    (out_valid),
		.stall    (out_stall),
		.item     (out_item)
	);

`ifndef ASSERT_OFF
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !accept |=> !valid_s1)
		else $error("input stage failed to drain");

	a_only_fire_steps: assert property (@(posedge clk) disable iff (!arst_n)
		step.count != 2'd0 |-> fire)
		else $error("result produced without an item");
`endif

endmodule

[tb/one_wire_rom_search_tb.sv]
// Self-checking regression of the 1-Wire ROM search engine against an emulated device bus
`timescale 1ns / 100ps

module one_wire_rom_search_tb;
	import ows_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int QuietLimit = 3000;
	localparam int ItemTarget = 700;

	class search_scoreboard;
		logic [7:0]  search_cmd;
		logic [63:0] rom, saved_rom;
		logic [6:0]  last_disc, saved_disc, bit_pos, zero_pos;
		logic [3:0]  fam_disc, saved_fam_disc;
		logic        last_dev, saved_last_dev, verify;
		logic [1:0]  phase;
		ows_out_t    pending_results[$];
		int          errors;

		function new();
			search_cmd = ResetSearchCmd;
			rom = '0;
			saved_rom = '0;
			last_disc = PosNone;
			saved_disc = PosNone;
			bit_pos = PosFirst;
			zero_pos = PosNone;
			fam_disc = '0;
			saved_fam_disc = '0;
			last_dev = 1'b0;
			saved_last_dev = 1'b0;
			verify = 1'b0;
			phase = PH_IDLE;
			errors = 0;
		endfunction

		function ows_out_t make_result(logic [1:0] act, logic [7:0] ob, logic dir, logic fnd,
				logic [63:0] rc, logic ld, logic lst);
			ows_out_t r;
			r.action = act;
			r.out_byte = ob;
			r.direction = dir;
			r.found = fnd;
			r.rom_code = rc;
			r.last_device = ld;
			r.last = lst;
			return r;
		endfunction

		function void clear_search();
			last_disc = PosNone;
			last_dev = 1'b0;
			fam_disc = '0;
		endfunction

		function void restore_saved();
			rom = saved_rom;
			last_disc = saved_disc;
			fam_disc = saved_fam_disc;
			last_dev = saved_last_dev;
		endfunction

		function void abandon();
			if (verify)
				restore_saved();
			verify = 1'b0;
			phase = PH_IDLE;
		endfunction

		function ows_out_t conclude(bit ok);
			bit res;
			res = ok;
			if (!ok)
				clear_search();
			if (verify) begin
				res = ok && (rom == saved_rom);
				restore_saved();
				verify = 1'b0;
			end
			phase = PH_IDLE;
			return make_result(ACT_FINISH, 8'h00, 1'b0, res, rom, last_dev, 1'b1);
		endfunction

		function ows_out_t start_search();
			phase = PH_PRESENCE;
			return make_result(ACT_BUS_RESET, 8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b1);
		endfunction

		function void accept_item(ows_in_t it, output int n, output ows_out_t r0,
				output ows_out_t r1);
			logic        dir;
			logic [63:0] mask;
			n = 0;
			r0 = '0;
			r1 = '0;
			case (it.cmd)
				CMD_NEXT: begin
					abandon();
					if (last_dev)
						r0 = conclude(1'b0);
					else
						r0 = start_search();
					n = 1;
				end
				CMD_FIRST: begin
					abandon();
					clear_search();
					r0 = start_search();
					n = 1;
				end
				CMD_VERIFY: begin
					abandon();
					saved_rom = rom;
					saved_disc = last_disc;
					saved_fam_disc = fam_disc;
					saved_last_dev = last_dev;
					last_disc = PosLast;
					last_dev = 1'b0;
					verify = 1'b1;
					r0 = start_search();
					n = 1;
				end
				CMD_TARGET: begin
					abandon();
					rom = {56'd0, it.fam_byte};
					last_disc = PosLast;
					fam_disc = '0;
					last_dev = 1'b0;
				end
				CMD_FAM_SKIP: begin
					abandon();
					last_disc = {3'd0, fam_disc};
					fam_disc = '0;
					if (last_disc == PosNone)
						last_dev = 1'b1;
				end
				CMD_PRESENCE: begin
					if (phase == PH_PRESENCE) begin
						if (it.no_presence) begin
							r0 = conclude(1'b0);
						end else begin
							phase = PH_SEARCH;
							bit_pos = PosFirst;
							zero_pos = PosNone;
							r0 = make_result(ACT_WR_BYTE, search_cmd, 1'b0, 1'b0, '0, 1'b0, 1'b1);
						end
						n = 1;
					end
				end
				CMD_BIT_PAIR: begin
					if (phase == PH_SEARCH) begin
						if (it.id_bit && it.cmp_bit) begin
							r0 = conclude(1'b0);
							n = 1;
						end else begin
							if (bit_pos < PosFirst || bit_pos > PosLast)
								bit_pos = PosFirst;
							mask = 64'd1 << (bit_pos - 1);
							if (it.id_bit != it.cmp_bit) begin
								dir = it.id_bit;
							end else begin
								if (bit_pos < last_disc)
									dir = (rom & mask) != 0;
								else
									dir = (bit_pos == last_disc);
								if (!dir) begin
									zero_pos = bit_pos;
									if (zero_pos < PosFamEnd)
										fam_disc = zero_pos[3:0];
								end
							end
							if (dir)
								rom = rom | mask;
							else
								rom = rom & ~mask;
							bit_pos = bit_pos + PosFirst;
							if (bit_pos <= PosLast) begin
								r0 = make_result(ACT_WR_DIR, 8'h00, dir, 1'b0, '0, 1'b0, 1'b1);
								n = 1;
							end else begin
								r0 = make_result(ACT_WR_DIR, 8'h00, dir, 1'b0, '0, 1'b0, 1'b0);
								last_disc = zero_pos;
								if (last_disc == PosNone)
									last_dev = 1'b1;
								r1 = conclude(rom[7:0] != 8'h00);
								n = 2;
							end
						end
					end
				end
				default: ;
			endcase
			if (n > 0)
				pending_results.push_back(r0);
			if (n > 1)
				pending_results.push_back(r1);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(ows_out_t got);
			ows_out_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("action", 64'(want.action), 64'(got.action));
			compare_field("out_byte", 64'(want.out_byte), 64'(got.out_byte));
			compare_field("direction", 64'(want.direction), 64'(got.direction));
			compare_field("found", 64'(want.found), 64'(got.found));
			compare_field("rom_code", want.rom_code, got.rom_code);
			compare_field("last_device", 64'(want.last_device), 64'(got.last_device));
			compare_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	ows_in_t    in_item;
	logic       out_valid;
	logic       out_stall;
	ows_out_t   out_item;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	search_scoreboard sb;
	bit          calm;
	int          items_sent;
	int          quiet_cycles;
	int          last_n;
	ows_out_t    last_r0, last_r1;
	logic [63:0] devices[$];
	logic [7:0]  alive;
	int          bus_pos;

	one_wire_rom_search dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic ows_in_t mk_item(logic [2:0] cmd);
		ows_in_t it;
		it.cmd = cmd;
		it.fam_byte = 8'($urandom_range(0, 255));
		it.no_presence = 1'($urandom_range(0, 1));
		it.id_bit = 1'($urandom_range(0, 1));
		it.cmp_bit = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic send_item(ows_in_t it);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.accept_item(it, last_n, last_r0, last_r1);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_cmd(logic [2:0] cmd);
		send_item(mk_item(cmd));
	endtask

	task automatic send_presence(logic nop);
		ows_in_t it;
		it = mk_item(CMD_PRESENCE);
		it.no_presence = nop;
		send_item(it);
	endtask

	task automatic send_pair(logic id, logic cmp);
		ows_in_t it;
		it = mk_item(CMD_BIT_PAIR);
		it.id_bit = id;
		it.cmp_bit = cmp;
		send_item(it);
	endtask

	task automatic send_target(logic [7:0] fam);
		ows_in_t it;
		it = mk_item(CMD_TARGET);
		it.fam_byte = fam;
		send_item(it);
	endtask

	// sender holds off until every outstanding result has been taken
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic write_cfg(logic [7:0] value);
		drain();
		repeat (4) @(negedge clk);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.search_cmd = value;
	endtask

	task automatic new_devices(int ep);
		int          count;
		logic [63:0] base, d;
		devices.delete();
		count = (ep == 0) ? 2 : $urandom_range(0, 4);
		base = {$urandom, $urandom};
		if (ep == 0 || $urandom_range(0, 5) == 0)
			base[7:0] = 8'h00;
		repeat (count) begin
			d = base;
			repeat ($urandom_range(0, 3)) d[$urandom_range(0, 63)] ^= 1'b1;
			if (ep != 0 && $urandom_range(0, 1) == 1)
				d[$urandom_range(0, 7)] ^= 1'b1;
			devices.push_back(d);
		end
	endtask

	// one search as a bus master would run it, answering bit pairs from the emulated devices
	task automatic run_search(logic [2:0] cmd, int abort_odds);
		logic id, cmp;
		send_cmd(cmd);
		if (last_n == 0 || last_r0.action != ACT_BUS_RESET)
			return;
		if ($urandom_range(0, 9) == 0)
			send_cmd(CMD_BIT_PAIR);
		send_presence(devices.size() == 0 || $urandom_range(0, 24) == 0);
		if (last_r0.action != ACT_WR_BYTE)
			return;
		alive = '1;
		bus_pos = 0;
		forever begin
			if (abort_odds != 0 && $urandom_range(1, abort_odds) == 1)
				return;
			id = 1'b1;
			cmp = 1'b1;
			foreach (devices[i]) begin
				if (alive[i]) begin
					id &= devices[i][bus_pos];
					cmp &= ~devices[i][bus_pos];
				end
			end
			if ($urandom_range(0, 199) == 0) begin
				id = 1'($urandom_range(0, 1));
				cmp = 1'($urandom_range(0, 1));
			end
			send_pair(id, cmp);
			if (last_n == 2 || last_r0.action == ACT_FINISH)
				return;
			foreach (devices[i]) begin
				if (devices[i][bus_pos] != last_r0.direction)
					alive[i] = 1'b0;
			end
			bus_pos++;
		end
	endtask

	initial begin
		int w;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			w = draw_wait();
			if (w != 0) begin
				out_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(out_item);
			@(negedge clk);
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QuietLimit) begin
				$display("one_wire_rom_search regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int         ep;
		int         odds;
		logic [7:0] fam;
		sb = new();
		calm = 1'b0;
		items_sent = 0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 8'h00;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_cfg(8'hEC);

		// directed: ignored events, failures, setup commands, abandoned searches
		send_cmd(CMD_UNUSED);
		send_cmd(CMD_PRESENCE);
		send_cmd(CMD_BIT_PAIR);
		send_cmd(CMD_NEXT);
		send_presence(1'b1);
		send_cmd(CMD_FIRST);
		send_presence(1'b0);
		send_pair(1'b1, 1'b1);
		send_target(8'hFF);
		send_target(8'h00);
		send_cmd(CMD_FAM_SKIP);
		send_cmd(CMD_NEXT);
		send_cmd(CMD_VERIFY);
		send_presence(1'b0);
		send_pair(1'b0, 1'b1);
		send_pair(1'b1, 1'b0);
		send_pair(1'b0, 1'b0);
		send_cmd(CMD_FIRST);
		send_presence(1'b0);
		send_pair(1'b0, 1'b0);
		send_cmd(CMD_VERIFY);
		send_cmd(CMD_FAM_SKIP);
		drain();

		ep = 0;
		while (items_sent < ItemTarget) begin
			new_devices(ep);
			calm = ($urandom_range(0, 3) == 0);
			if (ep == 0)
				write_cfg(8'h00);
			else if (ep == 1)
				write_cfg(8'hFF);
			else if ($urandom_range(0, 1) == 0)
				write_cfg($urandom_range(0, 1) ? ResetSearchCmd : 8'hEC);
			else
				write_cfg(8'($urandom_range(0, 255)));
			run_search(CMD_FIRST, 0);
			repeat ($urandom_range(4, 9)) begin
				if (items_sent < ItemTarget) begin
					odds = ($urandom_range(0, 3) == 0) ? 40 : 0;
					case ($urandom_range(0, 11))
						0, 1, 2, 3, 4: run_search(CMD_NEXT, odds);
						5, 6: run_search(CMD_VERIFY, odds);
						7: run_search(CMD_FIRST, odds);
						8: begin
							if (devices.size() != 0 && $urandom_range(0, 1) == 1)
								fam = devices[$urandom_range(0, devices.size() - 1)][7:0];
							else
								fam = 8'($urandom_range(0, 255));
							send_target(fam);
						end
						9: send_cmd(CMD_FAM_SKIP);
						10: begin
							case ($urandom_range(0, 2))
								0: send_cmd(CMD_UNUSED);
								1: send_cmd(CMD_PRESENCE);
								default: send_cmd(CMD_BIT_PAIR);
							endcase
						end
						default: drain();
					endcase
				end
			end
			ep++;
		end

		drain();
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("one_wire_rom_search regression: pass");
		else
			$display("one_wire_rom_search regression: fail");
		$finish;
	end

endmodule
